FILE: src/rkc_pkg.sv
// shared types, constants and helpers for the rgb kernel convolution block
package rkc_pkg;

   localparam int KSIZE_DEF     = 5;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MIN_WIDTH     = 3;
   localparam int KROWS         = 5;
   localparam int COEF_W        = 12;
   localparam int ROW_W         = KROWS * COEF_W;
   localparam int IW_W          = 12;
   localparam int COL_W         = 11;
   localparam int ROWCNT_W      = 16;
   localparam int FRAC_W        = 10;
   localparam int PROD_W        = 21;
   localparam int RSUM_W        = 24;
   localparam int TSUM_W        = 27;
   localparam int CSR_IDX_W     = 3;
   localparam int NCHAN         = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KROW_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KROW_LAST   = 3'd5;

   localparam logic [IW_W-1:0]  IMAGE_WIDTH_RST = 12'd640;
   localparam logic [ROW_W-1:0] KROW_CENTER_RST = 60'd17179869184;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]       blue_out;
      logic [7:0]       green_out;
      logic [7:0]       red_out;
      logic [COL_W-1:0] out_column;
      logic             row_end;
      logic             last_of_run;
   } rsp_type;

   typedef struct packed {
      pixel_type        pix;
      logic [COL_W-1:0] col;
      logic             at_end;
      logic             emit_ok;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             row_end;
      logic             last;
   } job_type;

   function automatic logic [7:0] chan(input pixel_type p, input int ch);
      logic [7:0] v;
      case (ch)
         0:       v = p.blue;
         1:       v = p.green;
         default: v = p.red;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] round_sat(input logic signed [TSUM_W-1:0] s);
      logic [TSUM_W-1:0] t;
      logic [TSUM_W-1:0] v;
      logic [7:0]        r;
      t = TSUM_W'(s) + TSUM_W'(1 << (FRAC_W - 1));
      v = t >> FRAC_W;
      if (s <= 0) begin
         r = 8'd0;
      end else if (v > TSUM_W'(255)) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

FILE: src/rgb_kernel_convolution.sv
// top level: register file, row and column counters, line store, window and filter
// Streams BGR pixels (top and bottom border rows already replicated) through a
// line store of 2*RADIUS rows and a TAPS x TAPS window, and gives each channel
// of the filtered pixel rounded and saturated to 0..255. One pixel is taken per
// cycle inside a row unless the output stalls; the last pixel of a row that
// produces output holds the input side while the window flushes the right edge.
// A result passes from the window stage through the job, product, row sum and
// output registers. The line store is one memory of MAX_WIDTH words, each word
// holding one column of all 2*RADIUS stored rows; it needs no clearing pass, and
// outputs start only after 2*RADIUS rows of a frame are in.
module rgb_kernel_convolution #(
   parameter int KSIZE     = rkc_pkg::KSIZE_DEF,
   parameter int MAX_WIDTH = rkc_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rkc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rkc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rkc_pkg::ROW_W-1:0]         csr_wdata
);

   localparam int RADIUS = KSIZE / 2;
   localparam int TAPS   = 2 * RADIUS + 1;
   localparam int LROWS  = 2 * RADIUS;
   localparam int PW     = (LROWS > 1) ? $clog2(LROWS) : 1;
   localparam int AW     = $clog2(MAX_WIDTH);

   logic [rkc_pkg::IW_W-1:0]                        iw_ff;
   logic [rkc_pkg::KROWS-1:0][rkc_pkg::ROW_W-1:0]   kern_ff;
   logic [rkc_pkg::COL_W-1:0]                       cc_ff;
   logic [rkc_pkg::ROWCNT_W-1:0]                    rc_ff;
   logic [PW-1:0]                                   ptr_ff;
   logic [rkc_pkg::CSR_IDX_W-1:0]                   krow_idx;

   logic [rkc_pkg::COL_W-1:0]    cc_eff;
   logic [rkc_pkg::ROWCNT_W-1:0] rc_eff;
   logic [PW-1:0]                ptr_eff;
   logic [rkc_pkg::IW_W-1:0]     w;
   logic [rkc_pkg::IW_W-1:0]     wm1;
   logic                         accept;
   rkc_pkg::item_type            item;

   rkc_pkg::pixel_type [LROWS-1:0]    rd_word;
   rkc_pkg::pixel_type [LROWS-1:0]    wr_word;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic                              job_valid;
   rkc_pkg::job_type                  job;
   logic                              mac_ready;
   rkc_pkg::pixel_type [TAPS*TAPS-1:0] win;

   assign accept   = req_valid && req_ready;
   assign krow_idx = csr_index - rkc_pkg::CSR_KROW_FIRST;

   always_comb begin
      if (iw_ff < rkc_pkg::IW_W'(rkc_pkg::MIN_WIDTH)) begin
         w = rkc_pkg::IW_W'(rkc_pkg::MIN_WIDTH);
      end else if (32'(iw_ff) > MAX_WIDTH) begin
         w = rkc_pkg::IW_W'(MAX_WIDTH);
      end else begin
         w = iw_ff;
      end
      wm1     = w - rkc_pkg::IW_W'(1);
      cc_eff  = req_data.frame_start ? '0 : cc_ff;
      rc_eff  = req_data.frame_start ? '0 : rc_ff;
      ptr_eff = req_data.frame_start ? '0 : ptr_ff;
      item.pix.blue  = req_data.blue_in;
      item.pix.green = req_data.green_in;
      item.pix.red   = req_data.red_in;
      item.at_end    = ({1'b0, cc_eff} >= wm1);
      item.col       = item.at_end ? rkc_pkg::COL_W'(wm1) : cc_eff;
      item.emit_ok   = (rc_eff >= rkc_pkg::ROWCNT_W'(LROWS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= rkc_pkg::IMAGE_WIDTH_RST;
         for (int i = 0; i < rkc_pkg::KROWS; i++) begin
            kern_ff[i] <= (i == rkc_pkg::KROWS / 2) ? rkc_pkg::KROW_CENTER_RST : '0;
         end
      end else if (csr_we) begin
         if (csr_index == rkc_pkg::CSR_IMAGE_WIDTH) begin
            iw_ff <= csr_wdata[rkc_pkg::IW_W-1:0];
         end else if (csr_index inside {[rkc_pkg::CSR_KROW_FIRST:rkc_pkg::CSR_KROW_LAST]}) begin
            kern_ff[krow_idx] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= '0;
         rc_ff  <= '0;
         ptr_ff <= '0;
      end else if (accept) begin
         if (item.at_end) begin
            cc_ff  <= '0;
            rc_ff  <= (rc_eff == '1) ? rc_eff : rc_eff + rkc_pkg::ROWCNT_W'(1);
            ptr_ff <= (ptr_eff == PW'(LROWS - 1)) ? '0 : ptr_eff + PW'(1);
         end else begin
            cc_ff  <= cc_eff + rkc_pkg::COL_W'(1);
            rc_ff  <= rc_eff;
            ptr_ff <= ptr_eff;
         end
      end
   end

   rkc_line_buffer #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (LROWS * 24)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (AW'(item.col)),
      .rd_data (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word)
   );

   rkc_window #(
      .KSIZE (KSIZE),
      .AW    (AW),
      .PW    (PW)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .in_load   (accept),
      .in_item   (item),
      .in_ptr    (ptr_eff),
      .in_ready  (req_ready),
      .rd_word   (rd_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_word   (wr_word),
      .job_valid (job_valid),
      .job       (job),
      .mac_ready (mac_ready),
      .win       (win)
   );

   rkc_mac #(
      .KSIZE (KSIZE)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_job    (job),
      .in_ready  (mac_ready),
      .win       (win),
      .kern      (kern_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/rkc_line_buffer.sv
// line store memory with read data registered and same-address forwarding
module rkc_line_buffer #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 96
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] q_ff;
   logic [DW-1:0] fwd_word_ff;
   logic          fwd_ff;
   logic          fwd_in;

   assign fwd_in  = wr_en && (wr_addr == rd_addr);
   assign rd_data = fwd_ff ? fwd_word_ff : q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= store_ff[rd_addr];
         fwd_word_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

FILE: src/rkc_window.sv
// column assembly, window registers and right-edge flush sequencing
module rkc_window #(
   parameter int KSIZE = rkc_pkg::KSIZE_DEF,
   parameter int AW    = 11,
   parameter int PW    = 2
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_load,
   input  rkc_pkg::item_type                                 in_item,
   input  logic [PW-1:0]                                     in_ptr,
   output logic                                              in_ready,
   input  rkc_pkg::pixel_type [2*(KSIZE/2)-1:0]              rd_word,
   output logic                                              wr_en,
   output logic [AW-1:0]                                     wr_addr,
   output rkc_pkg::pixel_type [2*(KSIZE/2)-1:0]              wr_word,
   output logic                                              job_valid,
   output rkc_pkg::job_type                                  job,
   input  logic                                              mac_ready,
   output rkc_pkg::pixel_type [(2*(KSIZE/2)+1)**2-1:0]       win
);

   localparam int RADIUS = KSIZE / 2;
   localparam int TAPS   = 2 * RADIUS + 1;
   localparam int LROWS  = 2 * RADIUS;
   localparam int FCW    = $clog2(RADIUS + 1);

   logic              s1_valid_ff;
   rkc_pkg::item_type item_ff;
   logic [PW-1:0]     ptr_ff;
   logic [FCW-1:0]    fc_ff;
   logic              job_valid_ff;
   rkc_pkg::job_type  job_ff;
   rkc_pkg::job_type  job_in;
   rkc_pkg::pixel_type win_ff [TAPS][TAPS];
   rkc_pkg::pixel_type colv [TAPS];

   logic step;
   logic last_step;
   logic emit_now;

   always_comb begin
      int s;
      for (int i = 0; i < LROWS; i++) begin
         s = int'(ptr_ff) + i;
         if (s >= LROWS) begin
            s = s - LROWS;
         end
         colv[i] = rd_word[PW'(s)];
      end
      colv[LROWS] = item_ff.pix;
      wr_word = rd_word;
      wr_word[ptr_ff] = item_ff.pix;
   end

   assign last_step = (fc_ff == ((item_ff.at_end && item_ff.emit_ok) ? FCW'(RADIUS) : '0));
   assign step      = s1_valid_ff && (!job_valid_ff || mac_ready);
   assign in_ready  = !s1_valid_ff || (step && last_step);
   assign emit_now  = item_ff.emit_ok &&
                      ((fc_ff != '0) || (item_ff.col >= rkc_pkg::COL_W'(RADIUS)));
   assign wr_en     = step && (fc_ff == '0);
   assign wr_addr   = AW'(item_ff.col);
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   always_comb begin
      if (fc_ff == '0) begin
         job_in.col     = item_ff.col - rkc_pkg::COL_W'(RADIUS);
         job_in.row_end = 1'b0;
         job_in.last    = !item_ff.at_end;
      end else begin
         job_in.col     = item_ff.col - rkc_pkg::COL_W'(RADIUS) + rkc_pkg::COL_W'(fc_ff);
         job_in.row_end = (fc_ff == FCW'(RADIUS));
         job_in.last    = (fc_ff == FCW'(RADIUS));
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            win[i*TAPS+j] = win_ff[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fc_ff        <= '0;
         job_valid_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (in_load) begin
            s1_valid_ff <= 1'b1;
            item_ff     <= in_item;
            ptr_ff      <= in_ptr;
            fc_ff       <= '0;
         end else if (step) begin
            fc_ff <= last_step ? '0 : fc_ff + FCW'(1);
            if (last_step) begin
               s1_valid_ff <= 1'b0;
            end
         end
         if (step) begin
            for (int i = 0; i < TAPS; i++) begin
               if ((fc_ff == '0) && (item_ff.col == '0)) begin
                  for (int j = 0; j < TAPS; j++) begin
                     win_ff[i][j] <= colv[i];
                  end
               end else begin
                  for (int j = 0; j < TAPS - 1; j++) begin
                     win_ff[i][j] <= win_ff[i][j+1];
                  end
                  win_ff[i][TAPS-1] <= colv[i];
               end
            end
         end
         if (!job_valid_ff || mac_ready) begin
            job_valid_ff <= step && emit_now;
            job_ff       <= job_in;
         end
      end
   end

endmodule

FILE: src/rkc_mac.sv
// parallel tap multipliers, row adders, final sum, rounding and output register
module rkc_mac #(
   parameter int KSIZE = rkc_pkg::KSIZE_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   input  rkc_pkg::job_type                                  in_job,
   output logic                                              in_ready,
   input  rkc_pkg::pixel_type [(2*(KSIZE/2)+1)**2-1:0]       win,
   input  logic [rkc_pkg::KROWS-1:0][rkc_pkg::ROW_W-1:0]     kern,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output rkc_pkg::rsp_type                                  rsp_data
);

   localparam int TAPS = 2 * (KSIZE / 2) + 1;

   logic signed [rkc_pkg::PROD_W-1:0] prod_ff [rkc_pkg::NCHAN][TAPS][TAPS];
   logic signed [rkc_pkg::RSUM_W-1:0] rsum_ff [rkc_pkg::NCHAN][TAPS];
   logic signed [rkc_pkg::RSUM_W-1:0] rsum_in [rkc_pkg::NCHAN][TAPS];
   logic signed [rkc_pkg::TSUM_W-1:0] tsum_in [rkc_pkg::NCHAN];
   rkc_pkg::job_type m_job_ff;
   rkc_pkg::job_type s_job_ff;
   rkc_pkg::rsp_type rsp_ff;
   logic m_valid_ff;
   logic s_valid_ff;
   logic rsp_valid_ff;
   logic rsp_load;
   logic s_ready;
   logic m_ready;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s_ready   = !s_valid_ff || rsp_load;
   assign m_ready   = !m_valid_ff || s_ready;
   assign in_ready  = m_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int c = 0; c < rkc_pkg::NCHAN; c++) begin
         tsum_in[c] = '0;
         for (int i = 0; i < TAPS; i++) begin
            rsum_in[c][i] = '0;
            for (int j = 0; j < TAPS; j++) begin
               rsum_in[c][i] = rsum_in[c][i] + rkc_pkg::RSUM_W'(prod_ff[c][i][j]);
            end
            tsum_in[c] = tsum_in[c] + rkc_pkg::TSUM_W'(rsum_ff[c][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready) begin
         m_job_ff <= in_job;
         for (int c = 0; c < rkc_pkg::NCHAN; c++) begin
            for (int i = 0; i < TAPS; i++) begin
               for (int j = 0; j < TAPS; j++) begin
                  prod_ff[c][i][j] <=
                     $signed({1'b0, rkc_pkg::chan(win[i*TAPS+j], c)}) *
                     $signed(kern[i][j*rkc_pkg::COEF_W +: rkc_pkg::COEF_W]);
               end
            end
         end
      end
      if (s_ready) begin
         s_job_ff <= m_job_ff;
         rsum_ff  <= rsum_in;
      end
      if (rsp_load) begin
         rsp_ff.blue_out    <= rkc_pkg::round_sat(tsum_in[0]);
         rsp_ff.green_out   <= rkc_pkg::round_sat(tsum_in[1]);
         rsp_ff.red_out     <= rkc_pkg::round_sat(tsum_in[2]);
         rsp_ff.out_column  <= s_job_ff.col;
         rsp_ff.row_end     <= s_job_ff.row_end;
         rsp_ff.last_of_run <= s_job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_valid_ff <= in_valid;
         end
         if (s_ready) begin
            s_valid_ff <= m_valid_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= s_valid_ff;
         end
      end
   end

endmodule

FILE: src/rkc_checker.sv
// port-level checks for the rgb kernel convolution block and their bind
module rkc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rkc_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_end |-> rsp_data.last_of_run)
      else $error("row end without last of run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (.*);

FILE: verif/rgb_kernel_convolution_tb.sv
// self-checking testbench for the rgb kernel convolution block
module rgb_kernel_convolution_tb;

   localparam int RAD   = rkc_pkg::KSIZE_DEF / 2;
   localparam int TAPS  = 2 * RAD + 1;
   localparam int LROWS = 2 * RAD;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   rkc_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   rkc_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [rkc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rkc_pkg::ROW_W-1:0]     csr_wdata;

   rgb_kernel_convolution dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rkc_pkg::req_type pixel_q[$];
   rkc_pkg::rsp_type filtered_q[$];
   int          send_idle_pct;
   int          stall_pct;
   int          errors = 0;
   logic        took;

   logic [rkc_pkg::IW_W-1:0]  width_reg;
   logic [rkc_pkg::ROW_W-1:0] krow [rkc_pkg::KROWS];
   logic [23:0]               line_mem [LROWS][rkc_pkg::MAX_WIDTH_DEF];
   logic [23:0]               win [TAPS*TAPS];
   logic [rkc_pkg::COL_W-1:0] col_cnt;
   logic [15:0]               row_cnt;
   int                        row_ptr;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int coef_of(int i, int j);
      logic signed [11:0] c;
      c = krow[i][12*j +: 12];
      return int'(c);
   endfunction

   function automatic logic [7:0] filter_chan(int sh);
      int sum;
      int v;
      sum = 0;
      for (int i = 0; i < TAPS; i++)
         for (int j = 0; j < TAPS; j++)
            sum += int'((win[i*TAPS+j] >> sh) & 24'hFF) * coef_of(i, j);
      if (sum <= 0) return 8'd0;
      v = (sum + 512) >>> 10;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   task automatic add_filtered(int col, logic rend, logic last);
      rkc_pkg::rsp_type r;
      r.blue_out    = filter_chan(0);
      r.green_out   = filter_chan(8);
      r.red_out     = filter_chan(16);
      r.out_column  = col[rkc_pkg::COL_W-1:0];
      r.row_end     = rend;
      r.last_of_run = last;
      filtered_q.insert(filtered_q.size(), r);
   endtask

   task automatic shift_window(logic [23:0] cv [TAPS]);
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j + 1 < TAPS; j++) win[i*TAPS+j] = win[i*TAPS+j+1];
         win[i*TAPS+TAPS-1] = cv[i];
      end
   endtask

   task automatic reset_model();
      for (int i = 0; i < TAPS*TAPS; i++) win[i] = '0;
      col_cnt = '0;
      row_cnt = '0;
      row_ptr = 0;
   endtask

   task automatic predict_pixel(rkc_pkg::req_type r);
      int w;
      int c;
      logic at_end;
      logic [23:0] pix;
      logic [23:0] cv [TAPS];
      w = int'(width_reg);
      if (w < rkc_pkg::MIN_WIDTH) w = rkc_pkg::MIN_WIDTH;
      if (w > rkc_pkg::MAX_WIDTH_DEF) w = rkc_pkg::MAX_WIDTH_DEF;
      if (r.frame_start) begin
         col_cnt = '0;
         row_cnt = '0;
         row_ptr = 0;
      end
      c = int'(col_cnt);
      if (c >= w) c = w - 1;
      at_end = int'(col_cnt) >= w - 1;
      pix = {r.red_in, r.green_in, r.blue_in};
      for (int i = 0; i < LROWS; i++) cv[i] = line_mem[(row_ptr + i) % LROWS][c];
      cv[LROWS] = pix;
      line_mem[row_ptr % LROWS][c] = pix;
      if (c == 0) begin
         for (int i = 0; i < TAPS; i++)
            for (int j = 0; j < TAPS; j++) win[i*TAPS+j] = cv[i];
      end else begin
         shift_window(cv);
      end
      if (row_cnt >= LROWS) begin
         if (c >= RAD) add_filtered(c - RAD, 1'b0, !at_end);
         if (at_end) begin
            for (int i = 1; i <= RAD; i++) begin
               shift_window(cv);
               add_filtered(c - RAD + i, i == RAD, i == RAD);
            end
         end
      end
      if (at_end) begin
         col_cnt = '0;
         if (row_cnt < 16'hFFFF) row_cnt++;
         row_ptr = (row_ptr + 1) % LROWS;
      end else begin
         col_cnt = col_cnt + rkc_pkg::COL_W'(1);
      end
   endtask

   always @(posedge clock) begin
      took <= !reset && req_valid && req_ready;
      if (reset) reset_model();
      else if (req_valid && req_ready) predict_pixel(req_data);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || took) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pixel_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rkc_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $error("unexpected transfer on result channel");
            errors++;
         end else begin
            e = filtered_q.pop_front();
            if (rsp_data.blue_out !== e.blue_out) begin
               $error("blue_out expected %0d actual %0d", e.blue_out, rsp_data.blue_out);
               errors++;
            end
            if (rsp_data.green_out !== e.green_out) begin
               $error("green_out expected %0d actual %0d", e.green_out, rsp_data.green_out);
               errors++;
            end
            if (rsp_data.red_out !== e.red_out) begin
               $error("red_out expected %0d actual %0d", e.red_out, rsp_data.red_out);
               errors++;
            end
            if (rsp_data.out_column !== e.out_column) begin
               $error("out_column expected %0d actual %0d", e.out_column,
                      rsp_data.out_column);
               errors++;
            end
            if (rsp_data.row_end !== e.row_end) begin
               $error("row_end expected %0d actual %0d", e.row_end, rsp_data.row_end);
               errors++;
            end
            if (rsp_data.last_of_run !== e.last_of_run) begin
               $error("last_of_run expected %0d actual %0d", e.last_of_run,
                      rsp_data.last_of_run);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || filtered_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [rkc_pkg::CSR_IDX_W-1:0] idx,
                            logic [rkc_pkg::ROW_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == rkc_pkg::CSR_IMAGE_WIDTH) width_reg = val[rkc_pkg::IW_W-1:0];
      else krow[idx - rkc_pkg::CSR_KROW_FIRST] = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [rkc_pkg::ROW_W-1:0] rand_row();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[rkc_pkg::ROW_W-1:0];
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_pixels(int n, logic first_start);
      rkc_pkg::req_type p;
      for (int k = 0; k < n; k++) begin
         p.blue_in     = rand_chan();
         p.green_in    = rand_chan();
         p.red_in      = rand_chan();
         p.frame_start = (k == 0) && first_start;
         pixel_q.insert(pixel_q.size(), p);
      end
   endtask

   task automatic write_kernel(int kind);
      logic [rkc_pkg::ROW_W-1:0] v;
      for (int i = 0; i < rkc_pkg::KROWS; i++) begin
         case (kind)
            0: v = (i == 2) ? rkc_pkg::KROW_CENTER_RST : '0;
            1: v = {rkc_pkg::KROWS{12'h800}};
            2: v = {rkc_pkg::KROWS{12'h7FF}};
            3: v = {rkc_pkg::KROWS{12'h029}};
            4: v = {5{12'($urandom_range(90)) - 12'd20}};
            default: v = rand_row();
         endcase
         write_reg(rkc_pkg::CSR_KROW_FIRST + 3'(i), v);
      end
   endtask

   initial begin
      int w;
      int total;
      send_idle_pct = 0;
      stall_pct     = 0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      width_reg     = rkc_pkg::IMAGE_WIDTH_RST;
      for (int i = 0; i < rkc_pkg::KROWS; i++)
         krow[i] = (i == 2) ? rkc_pkg::KROW_CENTER_RST : '0;
      total   = 0;
      reset   = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: minimum width from a too-small setting, reset kernel
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, rkc_pkg::ROW_W'(1));
      add_pixels(3 * 5, 1'b1);
      total += 3 * 5;
      wait_drained();
      write_kernel(1);
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, rkc_pkg::ROW_W'(0));
      add_pixels(3 * 5, 1'b1);
      total += 3 * 5;
      wait_drained();
      write_kernel(2);
      add_pixels(3 * 5, 1'b1);
      total += 3 * 5;
      wait_drained();

      // width shrunk in the middle of a row
      write_kernel(3);
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, rkc_pkg::ROW_W'(8));
      add_pixels(8 * 4 + 5, 1'b1);
      total += 8 * 4 + 5;
      wait_drained();
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, rkc_pkg::ROW_W'(3));
      add_pixels(3 * 3, 1'b0);
      total += 3 * 3;
      wait_drained();

      for (int ph = 0; total < 320; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         write_kernel($urandom_range(5));
         w = $urandom_range(12, 3);
         write_reg(rkc_pkg::CSR_IMAGE_WIDTH, rkc_pkg::ROW_W'(w));
         for (int f = 0; f < 2; f++) begin
            int rows;
            int extra;
            rows = $urandom_range(7, 5);
            add_pixels(w * rows, 1'b1);
            total += w * rows;
            if ($urandom_range(3) == 0) begin
               extra = $urandom_range(w * 3, 1);
               add_pixels(extra, 1'b1);
               total += extra;
            end
         end
         wait_drained();
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      wait_drained();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
